>>> sv/lisa_pkg.sv
// shared constants for the log interval spectrum averager
package lisa_pkg;

    localparam int unsigned DEF_MAX_SLOTS   = 256;
    localparam int unsigned DEF_MAX_LENGTH  = 4096;
    localparam int unsigned DEF_SAMPLE_BITS = 32;

    localparam int unsigned CFG_W      = 9;
    localparam int unsigned SLOT_NUM_W = 8;
    localparam int unsigned END_W      = 13;
    localparam int unsigned NUM_W      = 9;
    localparam int unsigned CENTRE_W   = 14;

    // running sum saturates at +-(2^62-1), so its magnitude fits 62 bits
    localparam int unsigned SUM_W = 63;
    localparam int unsigned MAG_W = 62;

    localparam logic [CFG_W-1:0] SLOTS_RESET = 9'd64;
    localparam logic [NUM_W-1:0] NUM_MAX     = 9'h1FF;
    localparam int unsigned      DROP_DIV    = 3;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

endpackage

>>> sv/lisa_div.sv
// restoring divider, one quotient bit per cycle, unsigned magnitude by count
module lisa_div #(
    parameter int unsigned DEN_W = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lisa_pkg::MAG_W-1:0]  i_num,
    input  logic [DEN_W-1:0]            i_den,
    output logic                        o_done,
    output logic [lisa_pkg::MAG_W-1:0]  o_quot
);

    localparam int unsigned CNT_W = $clog2(lisa_pkg::MAG_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [DEN_W-1:0]            r_den;
    logic [DEN_W-1:0]            r_rem;
    logic [lisa_pkg::MAG_W-1:0]  r_q;

    logic [DEN_W:0]              w_sh;
    logic                        w_ge;
    logic [DEN_W:0]              w_diff;

    always_comb begin
        w_sh   = {r_rem, r_q[lisa_pkg::MAG_W-1]};
        w_ge   = (w_sh >= {1'b0, r_den});
        w_diff = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(lisa_pkg::MAG_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
            r_q   <= {r_q[lisa_pkg::MAG_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> sv/log_interval_spectrum_averager.sv
// top level: log-spaced slot averaging of a spectrum with a sequenced divider
//
//  channel   direction  handshake                  payload
//  in        request    i_in_valid / o_in_ready    mode, slot number, end index, sample, last
//  out       result     o_out_valid / i_out_ready  point number, centre, mean, final flag
//  cfg       write      i_cfg_we                   slots in use (9 bits)
//
//  a table load is written in the idle state; a sample that closes no slot passes
//  through check and add; each empty slot skipped adds a look and a check; a slot
//  that closes with data also runs the 62-step restoring divider, then point and emit
//  a point waits for the output register; the sequencer also waits for the divider
//  reset is synchronous active low; the boundary table holds no reset value
module log_interval_spectrum_averager #(
    parameter int unsigned MAX_SLOTS   = lisa_pkg::DEF_MAX_SLOTS,
    parameter int unsigned MAX_LENGTH  = lisa_pkg::DEF_MAX_LENGTH,
    parameter int unsigned SAMPLE_BITS = lisa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lisa_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [lisa_pkg::SLOT_NUM_W-1:0]     i_slot_number,
    input  logic [lisa_pkg::END_W-1:0]          i_slot_end_index,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_value,
    input  logic                                i_last_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lisa_pkg::NUM_W-1:0]          o_point_number,
    output logic [lisa_pkg::CENTRE_W-1:0]       o_centre_half_bins,
    output logic signed [SAMPLE_BITS-1:0]       o_mean_value,
    output logic                                o_final_point
);

    localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
    localparam int unsigned IDX_W  = $clog2(2 * MAX_LENGTH);
    localparam int unsigned CW     = IDX_W + 2;
    localparam logic [IDX_W-1:0] INDEX_LIMIT = IDX_W'(2 * MAX_LENGTH - 1);
    localparam logic signed [63:0] SUM_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic [lisa_pkg::MAG_W-1:0] POS_LIM =
        lisa_pkg::MAG_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [lisa_pkg::MAG_W-1:0] NEG_LIM =
        lisa_pkg::MAG_W'(64'd1 << (SAMPLE_BITS - 1));

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_LOOK      = 4'd2;
    localparam logic [3:0] S_DIV       = 4'd3;
    localparam logic [3:0] S_POINT     = 4'd4;
    localparam logic [3:0] S_LOOP_EMIT = 4'd5;
    localparam logic [3:0] S_ADD       = 4'd6;
    localparam logic [3:0] S_LAST      = 4'd7;
    localparam logic [3:0] S_HELD_EMIT = 4'd8;
    localparam logic [3:0] S_NEW_EMIT  = 4'd9;

    logic [3:0]                         r_state;
    logic [lisa_pkg::CFG_W-1:0]         r_slots;
    logic [lisa_pkg::END_W-1:0]         r_table [MAX_SLOTS];
    logic [lisa_pkg::END_W-1:0]         r_tab_q;
    logic [SLOT_W-1:0]                  r_cur;
    logic [SLOT_W-1:0]                  r_last;
    logic [IDX_W-1:0]                   r_idx;
    logic signed [lisa_pkg::SUM_W-1:0]  r_sum;
    logic [IDX_W-1:0]                   r_cnt;
    logic [IDX_W-1:0]                   r_prev;
    logic [lisa_pkg::NUM_W-1:0]         r_pts;
    logic                               r_held_v;
    logic [lisa_pkg::NUM_W-1:0]         r_held_num;
    logic [lisa_pkg::CENTRE_W-1:0]      r_held_cen;
    logic signed [SAMPLE_BITS-1:0]      r_held_mean;
    logic [lisa_pkg::NUM_W-1:0]         r_new_num;
    logic [lisa_pkg::CENTRE_W-1:0]      r_new_cen;
    logic signed [SAMPLE_BITS-1:0]      r_new_mean;
    logic signed [SAMPLE_BITS-1:0]      r_samp;
    logic                               r_lastflag;
    logic                               r_emitted;
    logic                               r_fin;
    logic                               r_neg;
    logic [IDX_W-1:0]                   r_lidx;
    logic                               r_out_v;
    logic [lisa_pkg::NUM_W-1:0]         r_out_num;
    logic [lisa_pkg::CENTRE_W-1:0]      r_out_cen;
    logic signed [SAMPLE_BITS-1:0]      r_out_mean;
    logic                               r_out_fin;

    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_close;
    logic                               w_drop;
    logic [31:0]                        w_last_full;
    logic [lisa_pkg::SUM_W-1:0]         w_abs;
    logic                               w_div_start;
    logic                               w_div_done;
    logic [lisa_pkg::MAG_W-1:0]         w_quot;
    logic signed [63:0]                 w_sum_t;
    logic signed [lisa_pkg::SUM_W-1:0]  n_sum;
    logic [IDX_W-1:0]                   n_cnt;
    logic [IDX_W-1:0]                   n_idx;
    logic [lisa_pkg::NUM_W-1:0]         n_pts;
    logic signed [SAMPLE_BITS-1:0]      n_mean;
    logic [CW-1:0]                      w_span;
    logic [CW-1:0]                      w_cnt_c;
    logic [CW-1:0]                      w_cen;
    logic [CW-1:0]                      w_drop_lhs;

    logic                               w_push;
    logic [lisa_pkg::NUM_W-1:0]         w_push_num;
    logic [lisa_pkg::CENTRE_W-1:0]      w_push_cen;
    logic signed [SAMPLE_BITS-1:0]      w_push_mean;
    logic                               w_push_fin;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_v || i_out_ready;

    always_comb begin
        w_last_full = (r_slots == '0) ? 32'd0 : 32'(r_slots) - 32'd1;
        if (w_last_full > 32'(MAX_SLOTS - 1)) begin
            w_last_full = 32'(MAX_SLOTS - 1);
        end
        w_close = (r_cur < r_last) && (32'(r_tab_q) < 32'(r_idx));
        w_abs   = r_sum[lisa_pkg::SUM_W-1] ? -r_sum : r_sum;

        w_sum_t = 64'(r_sum) + 64'(r_samp);
        if (w_sum_t > SUM_LIM) begin
            w_sum_t = SUM_LIM;
        end else if (w_sum_t < -SUM_LIM) begin
            w_sum_t = -SUM_LIM;
        end
        n_sum = lisa_pkg::SUM_W'(w_sum_t);
        n_cnt = (r_cnt < INDEX_LIMIT) ? r_cnt + IDX_W'(1) : r_cnt;
        n_idx = (r_idx < INDEX_LIMIT) ? r_idx + IDX_W'(1) : r_idx;
        n_pts = (r_pts < lisa_pkg::NUM_MAX) ? r_pts + lisa_pkg::NUM_W'(1) : r_pts;

        // drop if a point was emitted, or when count < prev / 3, i.e. 3 * (count + 1) <= prev
        w_drop_lhs = CW'(lisa_pkg::DROP_DIV) * (CW'(r_cnt) + CW'(1));
        w_drop     = r_emitted || (w_drop_lhs <= CW'(r_prev));

        if (!r_neg) begin
            n_mean = (w_quot > POS_LIM) ? SAMPLE_BITS'(POS_LIM) : SAMPLE_BITS'(w_quot);
        end else begin
            n_mean = (w_quot > NEG_LIM) ? SAMPLE_BITS'(NEG_LIM) : -SAMPLE_BITS'(w_quot);
        end

        w_span  = (CW'(r_lidx) << 1) + CW'(2);
        w_cnt_c = CW'(r_cnt);
        if (r_cnt == IDX_W'(1)) begin
            w_cen = CW'(r_lidx) << 1;
        end else if (w_cnt_c > w_span) begin
            w_cen = '0;
        end else begin
            w_cen = w_span - w_cnt_c;
        end
    end

    always_comb begin
        w_div_start = 1'b0;
        w_push      = 1'b0;
        w_push_num  = r_held_num;
        w_push_cen  = r_held_cen;
        w_push_mean = r_held_mean;
        w_push_fin  = 1'b0;
        case (r_state)
            S_CHECK: begin
                w_div_start = w_close && (r_cnt != '0);
            end
            S_LAST: begin
                w_div_start = !w_drop;
                w_push      = w_drop && r_held_v && w_out_free;
                w_push_fin  = 1'b1;
            end
            S_LOOP_EMIT, S_HELD_EMIT: begin
                w_push = r_held_v && w_out_free;
            end
            S_NEW_EMIT: begin
                w_push      = w_out_free;
                w_push_num  = r_new_num;
                w_push_cen  = r_new_cen;
                w_push_mean = r_new_mean;
                w_push_fin  = 1'b1;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    lisa_div #(
        .DEN_W (IDX_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (lisa_pkg::MAG_W'(w_abs)),
        .i_den   (r_cnt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // boundary table
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_mode == lisa_pkg::MODE_LOAD)
                && (32'(i_slot_number) < 32'(MAX_SLOTS))) begin
            r_table[SLOT_W'(i_slot_number)] <= i_slot_end_index;
        end
        r_tab_q <= r_table[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= lisa_pkg::SLOTS_RESET;
        end else if (i_cfg_we) begin
            r_slots <= i_cfg_data;
        end
    end

    // sequencer and spectrum state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_idx     <= IDX_W'(1);
            r_sum     <= '0;
            r_cnt     <= '0;
            r_prev    <= '0;
            r_pts     <= '0;
            r_held_v  <= 1'b0;
            r_emitted <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_mode == lisa_pkg::MODE_SAMPLE)) begin
                        r_last     <= SLOT_W'(w_last_full);
                        r_samp     <= i_sample_value;
                        r_lastflag <= i_last_sample;
                        r_emitted  <= 1'b0;
                        r_state    <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!w_close) begin
                        r_state <= S_ADD;
                    end else if (r_cnt != '0) begin
                        r_lidx  <= r_idx - IDX_W'(1);
                        r_neg   <= r_sum[lisa_pkg::SUM_W-1];
                        r_fin   <= 1'b0;
                        r_state <= S_DIV;
                    end else begin
                        r_prev  <= r_cnt;
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_cur   <= r_cur + SLOT_W'(1);
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_CHECK;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_POINT;
                    end
                end
                S_POINT: begin
                    r_pts      <= n_pts;
                    r_new_num  <= n_pts;
                    r_new_cen  <= lisa_pkg::CENTRE_W'(w_cen);
                    r_new_mean <= n_mean;
                    r_state    <= r_fin ? S_HELD_EMIT : S_LOOP_EMIT;
                end
                S_LOOP_EMIT: begin
                    if (!r_held_v || w_out_free) begin
                        if (r_held_v) begin
                            r_emitted <= 1'b1;
                        end
                        r_held_v    <= 1'b1;
                        r_held_num  <= r_new_num;
                        r_held_cen  <= r_new_cen;
                        r_held_mean <= r_new_mean;
                        r_prev      <= r_cnt;
                        r_cnt       <= '0;
                        r_sum       <= '0;
                        r_cur       <= r_cur + SLOT_W'(1);
                        r_state     <= S_LOOK;
                    end
                end
                S_ADD: begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    if (r_lastflag) begin
                        r_state <= S_LAST;
                    end else begin
                        r_idx   <= n_idx;
                        r_state <= S_IDLE;
                    end
                end
                S_LAST: begin
                    if (!w_drop) begin
                        r_lidx  <= r_idx;
                        r_neg   <= r_sum[lisa_pkg::SUM_W-1];
                        r_fin   <= 1'b1;
                        r_state <= S_DIV;
                    end else if (!r_held_v || w_out_free) begin
                        r_cur    <= '0;
                        r_idx    <= IDX_W'(1);
                        r_sum    <= '0;
                        r_cnt    <= '0;
                        r_prev   <= '0;
                        r_pts    <= '0;
                        r_held_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_HELD_EMIT: begin
                    if (!r_held_v || w_out_free) begin
                        r_held_v <= 1'b0;
                        r_state  <= S_NEW_EMIT;
                    end
                end
                S_NEW_EMIT: begin
                    if (w_out_free) begin
                        r_cur    <= '0;
                        r_idx    <= IDX_W'(1);
                        r_sum    <= '0;
                        r_cnt    <= '0;
                        r_prev   <= '0;
                        r_pts    <= '0;
                        r_held_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_push) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_num  <= w_push_num;
            r_out_cen  <= w_push_cen;
            r_out_mean <= w_push_mean;
            r_out_fin  <= w_push_fin;
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_v;
    assign o_point_number     = r_out_num;
    assign o_centre_half_bins = r_out_cen;
    assign o_mean_value       = r_out_mean;
    assign o_final_point      = r_out_fin;

endmodule
